/* design/sli_pkg.sv */
// Shared types and constants for the sorted list insert/delete block.
// No dependencies; used by sli_ctrl, sli_datapath and sorted_list_insert_delete.
`default_nettype none

package sli_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 5;

    // command codes carried on s_axis_tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch operand and cell compare flags
        logic apply;    // shift cells, update count, load result register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* design/sli_ctrl.sv */
// Controller state machine: input handshake, sequencing, result valid.
// Depends on sli_pkg.
`default_nettype none

module sli_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sli_pkg::t_dp_cmd   o_dp_cmd
);

    sli_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sli_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sli_pkg::S_EXEC;
            end
            sli_pkg::S_EXEC: begin
                if (w_out_free) n_state = sli_pkg::S_IDLE;
            end
            default: n_state = sli_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_dp_cmd.capture = 1'b0;
        o_dp_cmd.apply   = 1'b0;
        unique case (r_state)
            sli_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_dp_cmd.capture = i_in_valid;
            end
            sli_pkg::S_EXEC: begin
                o_dp_cmd.apply = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_dp_cmd.apply) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sli_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* design/sli_datapath.sv */
// Datapath: row of compare-and-shift cells, entry count, order register, result register.
// Depends on sli_pkg.
`default_nettype none

module sli_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sli_pkg::t_dp_cmd              i_dp_cmd,
    input  wire logic                          i_in_cmd,
    input  wire logic [sli_pkg::VAL_W-1:0]     i_in_value,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic                          i_cfg_wr_data,
    output logic                               o_res_ok,
    output logic [sli_pkg::OUT_CNT_W-1:0]      o_res_count
);

    localparam int N = sli_pkg::DEPTH;
    localparam int W = sli_pkg::VAL_W;
    localparam int CW = sli_pkg::COUNT_W;

    logic [W-1:0]  r_store [N];
    logic [CW-1:0] r_count, n_count;
    logic          r_order;
    logic          r_cmd;
    logic [W-1:0]  r_val;
    logic [N-1:0]  r_after;  // value sorts after this held entry
    logic [N-1:0]  r_eq;     // held entry equals value
    logic [N-1:0]  n_after, n_eq;
    logic          r_ok;
    logic [sli_pkg::OUT_CNT_W-1:0] r_res_count;

    logic w_full, w_found, w_ok;

    // stage 1: parallel compares against the held entries
    for (genvar g = 0; g < N; g++) begin : g_cmp
        logic w_held;
        logic w_gt, w_lt;
        assign w_held = CW'(g) < r_count;
        assign w_gt   = $signed(i_in_value) > $signed(r_store[g]);
        assign w_lt   = $signed(i_in_value) < $signed(r_store[g]);
        assign n_after[g] = w_held && (r_order ? w_lt : w_gt);
        assign n_eq[g]    = w_held && (i_in_value == r_store[g]);
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_cmd   <= i_in_cmd;
            r_val   <= i_in_value;
            r_after <= n_after;
            r_eq    <= n_eq;
        end
    end

    // stage 2: shift decision per cell
    assign w_full  = r_count == CW'(N);
    assign w_found = |r_eq;
    assign w_ok    = (r_cmd == sli_pkg::CMD_INSERT) ? !w_full : w_found;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic [W-1:0] w_from_below;
        logic [W-1:0] w_from_above;
        logic [W-1:0] n_cell;
        logic         w_prev_after;
        if (g == 0) begin : g_first
            assign w_from_below = r_val;
            assign w_prev_after = 1'b1;
        end else begin : g_rest
            assign w_from_below = r_store[g-1];
            assign w_prev_after = r_after[g-1];
        end
        if (g == N - 1) begin : g_last
            assign w_from_above = r_store[g];
        end else begin : g_inner
            assign w_from_above = r_store[g+1];
        end

        always_comb begin
            n_cell = r_store[g];
            if (r_cmd == sli_pkg::CMD_INSERT) begin
                // lower-bound slot takes the value, later cells move up
                if (!r_after[g]) n_cell = w_prev_after ? r_val : w_from_below;
            end else begin
                // equal run is contiguous: first match and beyond move down
                if (!r_after[g]) n_cell = w_from_above;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_dp_cmd.apply && w_ok) r_store[g] <= n_cell;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_ok) begin
            if (r_cmd == sli_pkg::CMD_INSERT) n_count = r_count + CW'(1);
            else n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_order <= 1'b0;
        end else if (i_dp_cmd.apply) begin
            r_count <= n_count;
        end else if (i_cfg_wr_en && (i_cfg_wr_data != r_order)) begin
            // order change empties the list
            r_order <= i_cfg_wr_data;
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.apply) begin
            r_ok        <= w_ok;
            r_res_count <= sli_pkg::OUT_CNT_W'(n_count);
        end
    end

    assign o_res_ok    = r_ok;
    assign o_res_count = r_res_count;

endmodule

`default_nettype wire

/* design/sorted_list_insert_delete.sv */
// Sorted list insert/delete, top level: joins sli_ctrl and sli_datapath.
// Depends on sli_pkg, sli_ctrl, sli_datapath.
// The input transfer registers the operand and compare flags; the EXEC state then loads
// the cells, count and result register, and a stalled result holds the command there.
// A new command is taken only once the last is applied; the compare step checks the
// operand against all held entries in parallel, the shift step shifts the cells and updates the count.
// Reset (synchronous, active low) empties the list, selects ascending order and
// drops any pending result; cell contents are not cleared.
`default_nettype none

module sorted_list_insert_delete (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // command stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // [31:0] value (signed)
    input  wire logic         s_axis_tuser,   // [0] command: 0 insert, 1 delete
    // result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] ok, [5:1] entry_count, [7:6] zero
    // order register: 0 ascending, 1 descending
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_wr_data
);

    sli_pkg::t_dp_cmd                 w_dp_cmd;
    logic                             w_res_ok;
    logic [sli_pkg::OUT_CNT_W-1:0]    w_res_count;

    // Controller: accepts a transfer only when idle; the result register holds a
    // finished result while the next command is taken and compared.
    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dp_cmd    (w_dp_cmd)
    );

    // Datapath: one compare-and-shift cell per entry.
    sli_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (w_dp_cmd),
        .i_in_cmd      (s_axis_tuser),
        .i_in_value    (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res_ok      (w_res_ok),
        .o_res_count   (w_res_count)
    );

    assign m_axis_tdata = {2'b00, w_res_count, w_res_ok};

endmodule

`default_nettype wire
